FILE: rtl/watchdog_timer_registers_core_macros.svh
// ----------------------------------------------------------------------------
// Watchdog timer register block: assertion macros
// Concurrent assertion helpers clocked on i_clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef WATCHDOG_TIMER_REGISTERS_CORE_MACROS_SVH
`define WATCHDOG_TIMER_REGISTERS_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Consequent must hold in the same cycle as the antecedent.
`define WTR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define WTR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define WTR_ASSERT_NOW(lbl, ante, cons, msg)
`define WTR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: rtl/wtr_pkg.sv
// ----------------------------------------------------------------------------
// Watchdog timer register block: shared package
// Operation and register codes, control bit positions and the result type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wtr_pkg;

    // Operation codes.
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // Register select codes.
    localparam logic [1:0] SEL_CTRL = 2'd0;
    localparam logic [1:0] SEL_SVC  = 2'd1;
    localparam logic [1:0] SEL_WRSR = 2'd2;

    // Control register bit positions.
    localparam int unsigned BIT_WDA  = 5;
    localparam int unsigned BIT_WRE  = 3;
    localparam int unsigned BIT_WDE  = 2;
    localparam int unsigned BIT_WDBG = 1;

    localparam logic [15:0] CTRL_RESET      = 16'h0030;
    localparam logic [15:0] CTRL_FIRST_MASK = 16'hff3f;
    localparam logic [15:0] CTRL_LATER_MASK = 16'hff34;
    localparam logic [15:0] CTRL_STICKY     = 16'h000f;
    localparam logic [15:0] SVC_KEY_FIRST   = 16'h5555;
    localparam logic [15:0] SVC_KEY_SECOND  = 16'haaaa;
    localparam logic [15:0] WRSR_POWER_ON   = 16'h0010;

    typedef struct packed {
        logic [15:0] read_data;
        logic        nwdog_level;
        logic        system_reset;
        logic        bus_error;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/wtr_if.sv
// ----------------------------------------------------------------------------
// Watchdog timer register block: channel interfaces
// Valid/ready channels for register accesses and ticks, and for results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface wtr_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [1:0]  reg_select;
    logic [15:0] write_data;

    modport source (output valid, output operation, output reg_select,
                    output write_data, input ready);
    modport sink   (input valid, input operation, input reg_select,
                    input write_data, output ready);
endinterface

interface wtr_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] read_data;
    logic        nwdog_level;
    logic        system_reset;
    logic        bus_error;

    modport source (output valid, output read_data, output nwdog_level,
                    output system_reset, output bus_error, input ready);
    modport sink   (input valid, input read_data, input nwdog_level,
                    input system_reset, input bus_error, output ready);
endinterface

`default_nettype wire

FILE: rtl/wtr_core.sv
// ----------------------------------------------------------------------------
// Watchdog timer register block: register file and timer
// Holds the control, service and counter state and computes each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wtr_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire logic [1:0]       i_operation,
    input  wire logic [1:0]       i_reg_select,
    input  wire logic [15:0]      i_write_data,
    output wtr_pkg::t_result      o_result
);
    import wtr_pkg::*;

    logic [15:0] r_ctrl,    n_ctrl;
    logic        r_written, n_written;
    logic [15:0] r_svc,     n_svc;
    logic [7:0]  r_count,   n_count;
    logic        r_nwdog,   n_nwdog;

    logic [15:0] w_new_ctrl;
    logic [7:0]  w_dec;

    always_comb begin
        n_ctrl    = r_ctrl;
        n_written = r_written;
        n_svc     = r_svc;
        n_count   = r_count;
        n_nwdog   = r_nwdog;
        o_result  = '0;

        // Sticky low bits apply only once the control register has been written.
        w_new_ctrl = r_written ? ((i_write_data & CTRL_LATER_MASK) | (r_ctrl & CTRL_STICKY))
                               : (i_write_data & CTRL_FIRST_MASK);
        w_dec = (r_count != 8'd0) ? (r_count - 8'd1) : 8'd0;

        unique case (i_operation)
            OP_READ: begin
                unique case (i_reg_select)
                    SEL_CTRL: o_result.read_data = r_ctrl;
                    SEL_SVC:  o_result.read_data = r_svc;
                    SEL_WRSR: o_result.read_data = WRSR_POWER_ON;
                    default:  o_result.read_data = '0;
                endcase
            end
            OP_WRITE: begin
                unique case (i_reg_select)
                    SEL_CTRL: begin
                        n_ctrl    = w_new_ctrl;
                        n_written = 1'b1;
                        if (r_ctrl[BIT_WDE] != w_new_ctrl[BIT_WDE]) begin
                            n_count = w_new_ctrl[15:8];
                        end
                        // Reset mode with a zero timeout is a software reset.
                        if (!w_new_ctrl[BIT_WRE] && (w_new_ctrl[15:8] == 8'd0)) begin
                            o_result.system_reset = 1'b1;
                        end
                        n_nwdog = w_new_ctrl[BIT_WDA];
                    end
                    SEL_SVC: begin
                        if ((i_write_data == SVC_KEY_SECOND) && (r_svc == SVC_KEY_FIRST)) begin
                            n_count = r_ctrl[15:8];
                        end
                        n_svc = i_write_data;
                    end
                    SEL_WRSR: o_result.bus_error = 1'b1;
                    default: ;
                endcase
            end
            OP_TICK: begin
                if (r_ctrl[BIT_WDE] && !r_ctrl[BIT_WDBG]) begin
                    n_count = w_dec;
                    if (w_dec == 8'd0) begin
                        if (r_ctrl[BIT_WRE]) begin
                            n_nwdog = 1'b0;
                        end else begin
                            o_result.system_reset = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase

        o_result.nwdog_level = n_nwdog;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl    <= CTRL_RESET;
            r_written <= 1'b0;
            r_svc     <= '0;
            r_count   <= '0;
            r_nwdog   <= 1'b1;
        end else if (i_accept) begin
            r_ctrl    <= n_ctrl;
            r_written <= n_written;
            r_svc     <= n_svc;
            r_count   <= n_count;
            r_nwdog   <= n_nwdog;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/wtr_obuf.sv
// ----------------------------------------------------------------------------
// Watchdog timer register block: result buffer
// Two-entry result register so a new transfer can be taken during a stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wtr_obuf (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire wtr_pkg::t_result i_data,
    output logic                  o_ready,
    output logic                  o_valid,
    output wtr_pkg::t_result      o_data,
    input  wire logic             i_pop
);
    import wtr_pkg::*;

    logic [1:0] r_count, n_count;
    t_result    r_head,  n_head;
    t_result    r_tail,  n_tail;
    logic       w_pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_head;
    assign w_pop   = o_valid && i_pop;

    always_comb begin
        n_count = r_count;
        n_head  = r_head;
        n_tail  = r_tail;
        unique case (r_count)
            2'd0: begin
                if (i_push) begin
                    n_head  = i_data;
                    n_count = 2'd1;
                end
            end
            2'd1: begin
                if (w_pop && i_push) begin
                    n_head = i_data;
                end else if (w_pop) begin
                    n_count = 2'd0;
                end else if (i_push) begin
                    n_tail  = i_data;
                    n_count = 2'd2;
                end
            end
            default: begin
                // Full: no push can arrive, only the head can leave.
                if (w_pop) begin
                    n_head  = r_tail;
                    n_count = 2'd1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head <= n_head;
        r_tail <= n_tail;
    end

endmodule

`default_nettype wire

FILE: rtl/watchdog_timer_registers_core.sv
// ----------------------------------------------------------------------------
// Watchdog timer register block.
// The input channel carries one register read, register write or watchdog
// tick per transfer; the output channel returns exactly one result per
// input transfer, in order: read data, the nWDOG level after the access,
// a system reset request and a bus error flag.
// The result of a transfer is registered and offered on the output channel in
// the cycle after it is taken if the buffer was empty. Throughput is one
// transfer per cycle while the buffer has room; every register and counter
// update is done in the accepting cycle. A two-entry result buffer lets the
// block take one more transfer while the receiver stalls; the input is held
// off only when both entries are full. Reset is synchronous and active low:
// the control register returns to 0x0030, the service register and counter
// to zero, nWDOG is released and the result buffer empties.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "watchdog_timer_registers_core_macros.svh"

module watchdog_timer_registers_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    wtr_in_if.sink     i_in,
    wtr_out_if.source  o_res
);
    import wtr_pkg::*;

    logic    w_ready;
    logic    w_accept;
    t_result w_result;
    t_result w_head;

    assign i_in.ready = w_ready;
    assign w_accept   = i_in.valid && w_ready;

    wtr_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_operation  (i_in.operation),
        .i_reg_select (i_in.reg_select),
        .i_write_data (i_in.write_data),
        .o_result     (w_result)
    );

    wtr_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_data  (w_result),
        .o_ready (w_ready),
        .o_valid (o_res.valid),
        .o_data  (w_head),
        .i_pop   (o_res.ready)
    );

    assign o_res.read_data    = w_head.read_data;
    assign o_res.nwdog_level  = w_head.nwdog_level;
    assign o_res.system_reset = w_head.system_reset;
    assign o_res.bus_error    = w_head.bus_error;

    `WTR_ASSERT_NOW(a_berr_alone, w_accept && w_result.bus_error, (w_result.read_data == 16'd0) && !w_result.system_reset, "bus error result carries other flags")
    `WTR_ASSERT_NEXT(a_one_cycle, w_accept && !o_res.valid, o_res.valid, "result not offered one cycle after transfer")
    `WTR_ASSERT_NOW(a_ready_empty, !o_res.valid, w_ready, "input held off with an empty result buffer")

endmodule

`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Watchdog timer register block testbench
// Sends register reads, writes and watchdog ticks over the valid/ready input
// channel, predicts each result in step with the transfers taken, and checks
// every returned result field by field in order. Both sides idle at random,
// and the receiver once holds off long enough for the block to stall its input.
// ----------------------------------------------------------------------------
module testbench;
    import wtr_pkg::*;

    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam logic [1:0] SEL_UNUSED = 2'd3;
    localparam int unsigned N_ITEMS    = 650;
    localparam int unsigned IDLE_PCT   = 31;
    localparam int unsigned CALM_FIRST = 150;
    localparam int unsigned CALM_LAST  = 260;
    localparam int unsigned HOLD_AT    = 400;
    localparam int unsigned HOLD_LEN   = 60;

    typedef struct {
        logic [1:0]  op;
        logic [1:0]  sel;
        logic [15:0] data;
        bit          wait_drain;
    } t_access;

    logic i_clk = 1'b0;
    logic i_rst_n;

    wtr_in_if  acc_if ();
    wtr_out_if res_if ();

    watchdog_timer_registers_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (acc_if),
        .o_res   (res_if)
    );

    always #4 i_clk = ~i_clk;

    // Predicted watchdog state.
    logic [15:0] ctrl_word;
    logic        ctrl_written;
    logic [15:0] svc_word;
    logic [7:0]  wd_count;
    logic        nwdog;

    t_access     access_queue[$];
    t_result     pending_results[$];
    t_access     in_flight;
    t_access     nxt_access;
    t_result     got;
    t_result     want;
    bit          drain_next;
    bit          send_idle;
    bit          hold_done;
    int unsigned hold_cycles;
    int unsigned n_accepted;
    int unsigned n_checked;
    int unsigned n_sysrst;
    int unsigned n_berr;
    int unsigned err_count;

    function automatic t_result predict_watchdog(input t_access a);
        t_result     r;
        logic [15:0] old_ctrl;
        logic [15:0] new_ctrl;
        r = '0;
        case (a.op)
            OP_READ: begin
                case (a.sel)
                    SEL_CTRL: r.read_data = ctrl_word;
                    SEL_SVC:  r.read_data = svc_word;
                    SEL_WRSR: r.read_data = WRSR_POWER_ON;
                    default:  r.read_data = '0;
                endcase
            end
            OP_WRITE: begin
                case (a.sel)
                    SEL_CTRL: begin
                        old_ctrl = ctrl_word;
                        if (ctrl_written) begin
                            new_ctrl = (a.data & CTRL_LATER_MASK) | (old_ctrl & CTRL_STICKY);
                        end else begin
                            new_ctrl = a.data & CTRL_FIRST_MASK;
                            ctrl_written = 1'b1;
                        end
                        ctrl_word = new_ctrl;
                        if (old_ctrl[BIT_WDE] != new_ctrl[BIT_WDE]) begin
                            wd_count = new_ctrl[15:8];
                        end
                        // Reset mode with a zero timeout is a software reset.
                        if (!new_ctrl[BIT_WRE] && new_ctrl[15:8] == 8'd0) begin
                            r.system_reset = 1'b1;
                        end
                        nwdog = new_ctrl[BIT_WDA];
                    end
                    SEL_SVC: begin
                        if (a.data == SVC_KEY_SECOND && svc_word == SVC_KEY_FIRST) begin
                            wd_count = ctrl_word[15:8];
                        end
                        svc_word = a.data;
                    end
                    SEL_WRSR: r.bus_error = 1'b1;
                    default: ;
                endcase
            end
            OP_TICK: begin
                if (ctrl_word[BIT_WDE] && !ctrl_word[BIT_WDBG]) begin
                    if (wd_count != 8'd0) begin
                        wd_count = wd_count - 8'd1;
                    end
                    if (wd_count == 8'd0) begin
                        if (ctrl_word[BIT_WRE]) begin
                            nwdog = 1'b0;
                        end else begin
                            r.system_reset = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
        r.nwdog_level = nwdog;
        n_sysrst += r.system_reset;
        n_berr   += r.bus_error;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] exp_v,
                                        input logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            err_count++;
        end
    endfunction

    task automatic push_access(input logic [1:0] op, input logic [1:0] sel,
                               input logic [15:0] data);
        t_access a;
        a.op         = op;
        a.sel        = sel;
        a.data       = data;
        a.wait_drain = drain_next;
        drain_next   = 1'b0;
        access_queue.push_back(a);
    endtask

    task automatic push_ticks(input int unsigned n);
        repeat (n) push_access(OP_TICK, SEL_CTRL, 16'($urandom));
    endtask

    // Control write whose low byte only carries the bits allowed in this phase.
    task automatic push_ctrl_write(input logic [15:0] low_mask);
        logic [7:0] wt;
        case ($urandom_range(9))
            0:       wt = 8'd0;
            1:       wt = 8'($urandom);
            default: wt = 8'($urandom_range(6));
        endcase
        push_access(OP_WRITE, SEL_CTRL, {wt, 8'($urandom)} & low_mask);
    endtask

    task automatic push_service();
        case ($urandom_range(9))
            7: push_access(OP_WRITE, SEL_SVC, SVC_KEY_SECOND);
            8: begin
                push_access(OP_WRITE, SEL_SVC, SVC_KEY_FIRST);
                push_access(OP_WRITE, SEL_SVC, 16'($urandom));
            end
            9: push_access(OP_WRITE, SEL_SVC, 16'($urandom));
            default: begin
                push_access(OP_WRITE, SEL_SVC, SVC_KEY_FIRST);
                if ($urandom_range(3) == 0) begin
                    push_access($urandom_range(1) ? OP_TICK : OP_READ, SEL_SVC, 16'($urandom));
                end
                push_access(OP_WRITE, SEL_SVC, SVC_KEY_SECOND);
            end
        endcase
    endtask

    // Stimulus driver: one transfer offered at a time, held until taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            acc_if.valid <= 1'b0;
        end else begin
            if (acc_if.valid && acc_if.ready) begin
                pending_results.push_back(predict_watchdog(in_flight));
                n_accepted++;
            end
            if (!acc_if.valid || acc_if.ready) begin
                send_idle = !(n_accepted >= CALM_FIRST && n_accepted < CALM_LAST) &&
                            ($urandom_range(99) < IDLE_PCT);
                if (access_queue.size() != 0 && !send_idle &&
                    (!access_queue[0].wait_drain || pending_results.size() == 0)) begin
                    nxt_access = access_queue.pop_front();
                    in_flight  = nxt_access;
                    acc_if.valid      <= 1'b1;
                    acc_if.operation  <= nxt_access.op;
                    acc_if.reg_select <= nxt_access.sel;
                    acc_if.write_data <= nxt_access.data;
                end else begin
                    acc_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random back-pressure and one long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                got.read_data    = res_if.read_data;
                got.nwdog_level  = res_if.nwdog_level;
                got.system_reset = res_if.system_reset;
                got.bus_error    = res_if.bus_error;
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                    err_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("read_data", want.read_data, got.read_data);
                    check_field("nwdog_level", 16'(want.nwdog_level), 16'(got.nwdog_level));
                    check_field("system_reset", 16'(want.system_reset), 16'(got.system_reset));
                    check_field("bus_error", 16'(want.bus_error), 16'(got.bus_error));
                end
                n_checked++;
            end
            if (hold_cycles != 0) begin
                hold_cycles--;
                res_if.ready <= 1'b0;
            end else if (!hold_done && n_checked >= HOLD_AT) begin
                hold_done   = 1'b1;
                hold_cycles = HOLD_LEN;
                res_if.ready <= 1'b0;
            end else if (n_checked >= CALM_FIRST && n_checked < CALM_LAST) begin
                res_if.ready <= 1'b1;
            end else begin
                res_if.ready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    initial begin
        #1_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        logic [15:0] low_mask;
        int unsigned pick;
        i_rst_n           = 1'b0;
        acc_if.valid      = 1'b0;
        acc_if.operation  = OP_READ;
        acc_if.reg_select = SEL_CTRL;
        acc_if.write_data = '0;
        res_if.ready      = 1'b0;
        ctrl_word    = CTRL_RESET;
        ctrl_written = 1'b0;
        svc_word     = '0;
        wd_count     = '0;
        nwdog        = 1'b1;
        drain_next   = 1'b0;
        hold_done    = 1'b0;
        hold_cycles  = 0;
        n_accepted   = 0;
        n_checked    = 0;
        n_sysrst     = 0;
        n_berr       = 0;
        err_count    = 0;

        // Directed: reset values, unused codes, the read-only status register,
        // the first control write, a timeout in reset mode, the service
        // sequence and a software reset.
        push_access(OP_READ, SEL_CTRL, 16'h0000);
        push_access(OP_READ, SEL_SVC, 16'hffff);
        push_access(OP_READ, SEL_WRSR, 16'h0000);
        push_access(OP_READ, SEL_UNUSED, 16'h0000);
        push_access(OP_UNUSED, SEL_UNUSED, 16'hffff);
        push_access(OP_WRITE, SEL_WRSR, 16'hffff);
        push_access(OP_WRITE, SEL_UNUSED, 16'h1234);
        push_access(OP_TICK, SEL_CTRL, 16'h0000);
        push_access(OP_WRITE, SEL_CTRL, 16'h03e4);
        push_access(OP_READ, SEL_CTRL, 16'h0000);
        push_ticks(4);
        push_access(OP_WRITE, SEL_SVC, SVC_KEY_FIRST);
        push_access(OP_READ, SEL_SVC, 16'h0000);
        push_access(OP_WRITE, SEL_SVC, SVC_KEY_SECOND);
        push_access(OP_WRITE, SEL_SVC, SVC_KEY_SECOND);
        push_ticks(2);
        push_access(OP_WRITE, SEL_CTRL, 16'h0000);
        push_access(OP_WRITE, SEL_CTRL, 16'hff20);
        push_access(OP_READ, SEL_CTRL, 16'hffff);

        // Random: WRE only becomes settable midway and WDBG near the end,
        // as neither can be cleared once set.
        while (access_queue.size() < N_ITEMS) begin
            if (access_queue.size() < 250) begin
                low_mask = 16'hff35;
            end else if (access_queue.size() < 520) begin
                low_mask = 16'hff3d;
            end else begin
                low_mask = 16'hffff;
            end
            if (access_queue.size() >= 330 && access_queue.size() < 334) begin
                drain_next = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 45) begin
                push_ticks($urandom_range(1, 8));
            end else if (pick < 65) begin
                push_service();
            end else if (pick < 80) begin
                push_ctrl_write(low_mask);
            end else if (pick < 90) begin
                push_access(OP_READ, 2'($urandom), 16'($urandom));
            end else begin
                push_access(2'($urandom), 2'($urandom), 16'($urandom));
                if (access_queue[$].op == OP_WRITE && access_queue[$].sel == SEL_CTRL) begin
                    access_queue[$].data &= low_mask;
                end
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (access_queue.size() != 0 || acc_if.valid || pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);

        $display("Sent %0d reads, writes and ticks and checked %0d results;", n_accepted,
                 n_checked);
        $display("%0d system reset requests and %0d bus errors were predicted.", n_sysrst,
                 n_berr);
        if (err_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/wtr_pkg.sv
rtl/wtr_if.sv
rtl/wtr_core.sv
rtl/wtr_obuf.sv
rtl/watchdog_timer_registers_core.sv
sim/testbench.sv
